>>> rtl/core/fwh_pkg.sv
package fwh_pkg;

  localparam int DEF_CAPACITY = 512;
  localparam int DEF_ARITY    = 5;
  localparam int VAL_W        = 32;
  localparam int CNT_W        = 10;

  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_DEL_MIN = 2'd1,
    REQ_DEL_MAX = 2'd2,
    REQ_NOP     = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Signed order as unsigned compare.
  function automatic logic key_lt(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
    key_lt = {~a[VAL_W-1], a[VAL_W-2:0]} < {~b[VAL_W-1], b[VAL_W-2:0]};
  endfunction

endpackage

>>> rtl/core/fwh_ram.sv
module fwh_ram import fwh_pkg::*; #(
  parameter int DEPTH = DEF_CAPACITY,
  parameter int AW    = $clog2(DEF_CAPACITY)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [VAL_W-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [VAL_W-1:0] rdata
);

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/five_way_min_heap_queue_core.sv
// Steps: each request ends with a root read and, unless the heap is then empty, a leaf scan
// of the resulting heap for the greatest value. Insert first sifts up; delete-min reads the
// last entry and the root, then sifts down; delete-max reads the last entry, scans the old
// heap's leaves and sifts up. The longest request is a delete-max on a full 512-entry heap.
// Throughput: one item at a time; in_tready is high only while idle, which starts the cycle
// the result is registered. Reset (rst_n, synchronous, active low) empties the heap.
module five_way_min_heap_queue_core import fwh_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int ARITY    = DEF_ARITY
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [39:0]   in_tdata,   // [1:0] req_type, [33:2] item_value
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [111:0]  out_tdata   // [1:0] status, [33:2] removed_value,
                                    // [43:34] entry_count, [75:44] least_value,
                                    // [107:76] greatest_value
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int NW    = $clog2(CAPACITY + 1);
  localparam int AR_W  = $clog2(ARITY + 1);
  localparam int CW    = NW + 4;
  // x / ARITY as (x * RECIP) >> SH, exact for every x below 2**NW
  localparam int SH    = NW + 3;
  localparam int RECIP = (1 << SH) / ARITY + 1;
  localparam int PW    = 2 * NW + 3;

  typedef enum logic [16:0] {
    S_IDLE   = 17'h00001,
    S_LAST   = 17'h00002,
    S_LASTW  = 17'h00004,
    S_TOP    = 17'h00008,
    S_TOPW   = 17'h00010,
    S_DOWN   = 17'h00020,
    S_CH     = 17'h00040,
    S_CHW    = 17'h00080,
    S_DEC    = 17'h00100,
    S_UP     = 17'h00200,
    S_UPW    = 17'h00400,
    S_SCAN   = 17'h00800,
    S_SCANW  = 17'h01000,
    S_MAXFIX = 17'h02000,
    S_ROOT   = 17'h04000,
    S_ROOTW  = 17'h08000,
    S_OUT    = 17'h10000
  } state_t;

  state_t state_r;
  req_t req_r;
  logic [VAL_W-1:0] val_r, moved_r, best_v_r, rem_r, least_r;
  logic [NW-1:0] cnt_r, idx_r, par_r, best_i_r, hole_r, cidx_r, lim_r;
  logic [AR_W-1:0] cnum_r;
  status_t status_r;
  logic final_scan_r;
  logic scan_first_r;
  logic [111:0] odata_r;
  logic ovalid_r;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [VAL_W-1:0] wdata, rdata;
  logic [NW-1:0] ra_full, wa_full;
  logic [NW-1:0] parent_idx;
  logic [CW-1:0] child0;
  logic [VAL_W-1:0] cmp_a, cmp_b;
  logic cmp_lt;
  logic more_ch;
  logic last_scan;
  logic out_load;

  function automatic logic [NW-1:0] div_ar(input logic [NW-1:0] x);
    logic [PW-1:0] prod;
    prod = PW'(x) * PW'(RECIP);
    div_ar = prod[SH +: NW];
  endfunction

  function automatic logic [NW-1:0] first_leaf(input logic [NW-1:0] n);
    first_leaf = (n < NW'(2)) ? '0 : div_ar(n - NW'(2)) + NW'(1);
  endfunction

  fwh_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign raddr = ra_full[AW-1:0];
  assign waddr = wa_full[AW-1:0];
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata = odata_r;
  assign out_load = (state_r == S_OUT) && (!ovalid_r || out_tready);

  assign parent_idx = div_ar(idx_r - NW'(1));
  assign child0 = CW'(hole_r) * CW'(ARITY) + CW'(1);
  assign more_ch = (cnum_r + AR_W'(1) < AR_W'(ARITY)) && (cidx_r + NW'(1) < cnt_r);
  assign last_scan = (idx_r + NW'(1) >= lim_r);

  // Shared key comparator: cmp_lt = cmp_a < cmp_b in signed order
  always_comb begin
    case (state_r)
      S_CHW: begin
        cmp_a = rdata;
        cmp_b = best_v_r;
      end
      S_DEC: begin
        cmp_a = best_v_r;
        cmp_b = moved_r;
      end
      S_SCANW: begin
        cmp_a = best_v_r;
        cmp_b = rdata;
      end
      default: begin
        cmp_a = val_r;
        cmp_b = rdata;
      end
    endcase
  end

  assign cmp_lt = key_lt(cmp_a, cmp_b);

  always_comb begin
    case (state_r)
      S_LAST, S_SCAN: ra_full = idx_r;
      S_UP: ra_full = parent_idx;
      S_CH: ra_full = cidx_r;
      default: ra_full = '0;
    endcase
  end

  // Sequencer: every memory read has an issue state and a wait state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (out_load) begin
        ovalid_r <= 1'b1;
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            req_r <= req_t'(in_tdata[1:0]);
            val_r <= in_tdata[33:2];
            rem_r <= '0;
            case (req_t'(in_tdata[1:0]))
              REQ_INSERT: begin
                if (cnt_r >= NW'(CAPACITY)) begin
                  status_r <= ST_FULL;
                  state_r <= S_ROOT;
                end else begin
                  status_r <= ST_OK;
                  idx_r <= cnt_r;
                  cnt_r <= cnt_r + NW'(1);
                  state_r <= S_UP;
                end
              end
              REQ_DEL_MIN, REQ_DEL_MAX: begin
                if (cnt_r == '0) begin
                  status_r <= ST_EMPTY;
                  state_r <= S_ROOT;
                end else begin
                  // fetch the last entry first
                  status_r <= ST_OK;
                  idx_r <= cnt_r - NW'(1);
                  state_r <= S_LAST;
                end
              end
              default: begin
                status_r <= ST_OK;
                state_r <= S_ROOT;
              end
            endcase
          end
        end
        S_LAST: state_r <= S_LASTW;
        S_LASTW: begin
          moved_r <= rdata;
          cnt_r <= cnt_r - NW'(1);
          if (cnt_r == NW'(1)) begin
            rem_r <= rdata;
            state_r <= S_ROOT;
          end else if (req_r == REQ_DEL_MIN) begin
            state_r <= S_TOP;
          end else begin
            // leaf scan over the old heap, last entry included
            idx_r <= first_leaf(cnt_r);
            lim_r <= cnt_r;
            scan_first_r <= 1'b1;
            final_scan_r <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_TOP: state_r <= S_TOPW;
        S_TOPW: begin
          rem_r <= rdata;
          hole_r <= '0;
          state_r <= S_DOWN;
        end
        S_DOWN: begin
          if (child0 < CW'(cnt_r)) begin
            cidx_r <= child0[NW-1:0];
            cnum_r <= '0;
            state_r <= S_CH;
          end else begin
            state_r <= S_ROOT;
          end
        end
        S_CH: state_r <= S_CHW;
        S_CHW: begin
          if (cnum_r == '0 || cmp_lt) begin
            best_v_r <= rdata;
            best_i_r <= cidx_r;
          end
          if (more_ch) begin
            cidx_r <= cidx_r + NW'(1);
            cnum_r <= cnum_r + AR_W'(1);
            state_r <= S_CH;
          end else begin
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          // promote the least child into the hole or drop the moved entry there
          if (cmp_lt) begin
            hole_r <= best_i_r;
            state_r <= S_DOWN;
          end else begin
            state_r <= S_ROOT;
          end
        end
        S_UP: begin
          if (idx_r == '0) begin
            state_r <= S_ROOT;
          end else begin
            par_r <= parent_idx;
            state_r <= S_UPW;
          end
        end
        S_UPW: begin
          if (cmp_lt) begin
            idx_r <= par_r;
            state_r <= S_UP;
          end else begin
            state_r <= S_ROOT;
          end
        end
        S_SCAN: state_r <= S_SCANW;
        S_SCANW: begin
          scan_first_r <= 1'b0;
          if (scan_first_r || cmp_lt) begin
            best_v_r <= rdata;
            best_i_r <= idx_r;
          end
          if (last_scan) begin
            state_r <= final_scan_r ? S_OUT : S_MAXFIX;
          end else begin
            idx_r <= idx_r + NW'(1);
            state_r <= S_SCAN;
          end
        end
        S_MAXFIX: begin
          rem_r <= best_v_r;
          if (best_i_r < cnt_r) begin
            val_r <= moved_r;
            idx_r <= best_i_r;
            state_r <= S_UP;
          end else begin
            state_r <= S_ROOT;
          end
        end
        S_ROOT: state_r <= S_ROOTW;
        S_ROOTW: begin
          least_r <= rdata;
          if (cnt_r == '0) begin
            state_r <= S_OUT;
          end else begin
            final_scan_r <= 1'b1;
            scan_first_r <= 1'b1;
            idx_r <= first_leaf(cnt_r);
            lim_r <= cnt_r;
            state_r <= S_SCAN;
          end
        end
        S_OUT: begin
          if (out_load) begin
            odata_r <= {4'b0,
                        (cnt_r == '0) ? 32'b0 : best_v_r,
                        (cnt_r == '0) ? 32'b0 : least_r,
                        CNT_W'(cnt_r), rem_r, status_r};
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Write port: final places of sift-up and sift-down, and moves along the path.
  always_comb begin
    we = 1'b0;
    wa_full = idx_r;
    wdata = val_r;
    case (state_r)
      S_UP: we = (idx_r == '0);
      S_UPW: begin
        we = 1'b1;
        wdata = cmp_lt ? rdata : val_r;
      end
      S_DOWN: begin
        we = !(child0 < CW'(cnt_r));
        wa_full = hole_r;
        wdata = moved_r;
      end
      S_DEC: begin
        we = 1'b1;
        wa_full = hole_r;
        wdata = cmp_lt ? best_v_r : moved_r;
      end
      default: we = 1'b0;
    endcase
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NW'(CAPACITY)) else $error("count above capacity");
  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_tready) |=> $stable(odata_r)) else $error("result changed");
`endif

endmodule

>>> dv/tb_five_way_min_heap_queue_core.sv
`timescale 1ns / 100ps

module tb_five_way_min_heap_queue_core;
  import fwh_pkg::*;

  localparam int CAP = DEF_CAPACITY;
  localparam int AR  = DEF_ARITY;

  // lowest field last, to match the out_tdata packing
  typedef struct packed {
    logic [31:0] greatest;
    logic [31:0] least;
    logic [9:0]  count;
    logic [31:0] removed;
    status_t     status;
  } heap_result_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [39:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [111:0] out_tdata;
  logic in_fire;

  five_way_min_heap_queue_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  logic [39:0]  pending_reqs[$];
  heap_result_t expected_results[$];
  logic [31:0]  shadow_heap[CAP];
  int           shadow_count;
  int           mismatches;
  bit           calm_phase;
  int           send_gap;
  int           recv_gap;
  int           hold_off;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit lt_signed(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic void sift_toward_root(int pos);
    int parent;
    logic [31:0] t;
    while (pos > 0) begin
      parent = (pos - 1) / AR;
      if (!lt_signed(shadow_heap[pos], shadow_heap[parent])) break;
      t = shadow_heap[pos];
      shadow_heap[pos] = shadow_heap[parent];
      shadow_heap[parent] = t;
      pos = parent;
    end
  endfunction

  function automatic int largest_leaf();
    int best;
    best = (shadow_count < 2) ? 0 : (shadow_count - 2) / AR + 1;
    for (int i = best + 1; i < shadow_count; i++)
      if (lt_signed(shadow_heap[best], shadow_heap[i])) best = i;
    return best;
  endfunction

  // Apply one request to the shadow heap and return the result it yields.
  function automatic heap_result_t apply_request(logic [39:0] req_word);
    heap_result_t r;
    req_t        req;
    logic [31:0] val;
    logic [31:0] moved;
    int          hole;
    int          first;
    int          best;
    int          m;
    req = req_t'(req_word[1:0]);
    val = req_word[33:2];
    r = '0;
    r.status = ST_OK;
    if (req == REQ_INSERT) begin
      if (shadow_count >= CAP) r.status = ST_FULL;
      else begin
        shadow_heap[shadow_count] = val;
        shadow_count++;
        sift_toward_root(shadow_count - 1);
      end
    end else if (req == REQ_DEL_MIN || req == REQ_DEL_MAX) begin
      if (shadow_count == 0) r.status = ST_EMPTY;
      else if (req == REQ_DEL_MIN) begin
        r.removed = shadow_heap[0];
        moved = shadow_heap[shadow_count - 1];
        shadow_count--;
        if (shadow_count > 0) begin
          hole = 0;
          while (AR * hole + 1 < shadow_count) begin
            first = AR * hole + 1;
            best = first;
            for (int c = first + 1; c < first + AR && c < shadow_count; c++)
              if (lt_signed(shadow_heap[c], shadow_heap[best])) best = c;
            shadow_heap[hole] = shadow_heap[best];
            hole = best;
          end
          shadow_heap[hole] = moved;
          sift_toward_root(hole);
        end
      end else begin
        m = largest_leaf();
        r.removed = shadow_heap[m];
        shadow_count--;
        if (m < shadow_count) begin
          shadow_heap[m] = shadow_heap[shadow_count];
          sift_toward_root(m);
        end
      end
    end
    r.count = shadow_count[9:0];
    if (shadow_count > 0) begin
      r.least = shadow_heap[0];
      r.greatest = shadow_heap[largest_leaf()];
    end
    return r;
  endfunction

  function automatic logic [39:0] make_req(req_t req, logic [31:0] val);
    return {6'd0, val, req};
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7fff_ffff - $urandom_range(0, 3);
      2: return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  // Record the input handshake so the driver advances only after acceptance
  always @(posedge clk) begin
    in_fire <= rst_n && in_tvalid && in_tready;
  end

  // Driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_fire) begin
      // hold the offered item
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      in_tvalid <= 1'b0;
    end else if (pending_reqs.size() > 0) begin
      in_tvalid <= 1'b1;
      in_tdata <= pending_reqs.pop_front();
      if (!calm_phase && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 5);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Receiver backpressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!calm_phase && $urandom_range(0, 5) == 0) recv_gap <= $urandom_range(1, 5);
    end
  end

  // Monitor: predict on input acceptance, check on output acceptance
  always @(posedge clk) begin
    heap_result_t got;
    heap_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) expected_results.push_back(apply_request(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata[107:0];
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_tdata);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.removed !== want.removed ||
              got.count !== want.count || got.least !== want.least ||
              got.greatest !== want.greatest) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st=%0d rm=%h n=%0d lo=%h hi=%h %s",
                       want.status, want.removed, want.count, want.least,
                       want.greatest, "got");
            if (mismatches <= 10)
              $display("          got st=%0d rm=%h n=%0d lo=%h hi=%h",
                       got.status, got.removed, got.count, got.least, got.greatest);
          end
        end
      end
    end
  end

  initial begin
    #100_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int k;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    shadow_count = 0;
    mismatches = 0;
    calm_phase = 0;
    send_gap = 0;
    recv_gap = 0;
    hold_off = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: deletes on empty, extremes, equal values, unused code
    pending_reqs.push_back(make_req(REQ_DEL_MIN, 32'h1234_5678));
    pending_reqs.push_back(make_req(REQ_DEL_MAX, '1));
    pending_reqs.push_back(make_req(REQ_NOP, '1));
    pending_reqs.push_back(make_req(REQ_INSERT, 32'h7fff_ffff));
    pending_reqs.push_back(make_req(REQ_INSERT, 32'h8000_0000));
    pending_reqs.push_back(make_req(REQ_INSERT, 32'h0000_0000));
    pending_reqs.push_back(make_req(REQ_INSERT, 32'hffff_ffff));
    pending_reqs.push_back(make_req(REQ_INSERT, 32'h5555_5555));
    pending_reqs.push_back(make_req(REQ_INSERT, 32'haaaa_aaaa));
    pending_reqs.push_back(make_req(REQ_INSERT, 32'h0000_0005));
    pending_reqs.push_back(make_req(REQ_INSERT, 32'h0000_0005));
    pending_reqs.push_back(make_req(REQ_INSERT, 32'h7fff_ffff));
    pending_reqs.push_back(make_req(REQ_NOP, 32'h0));
    pending_reqs.push_back(make_req(REQ_DEL_MAX, 32'h0));
    pending_reqs.push_back(make_req(REQ_DEL_MIN, 32'h0));
    pending_reqs.push_back(make_req(REQ_DEL_MAX, 32'h0));
    pending_reqs.push_back(make_req(REQ_DEL_MIN, 32'h0));
    for (int i = 0; i < 6; i++) pending_reqs.push_back(make_req(REQ_DEL_MIN, 32'h0));
    pending_reqs.push_back(make_req(REQ_DEL_MAX, 32'h0));

    // Long receiver hold-off while the sender keeps offering
    hold_off = 300;

    // Fill to capacity, push against full, then a short mix on the full heap
    for (int i = 0; i < CAP + 3; i++) pending_reqs.push_back(make_req(REQ_INSERT, rand_value()));
    for (int i = 0; i < 12; i++) begin
      k = $urandom_range(0, 99);
      if (k < 30) pending_reqs.push_back(make_req(REQ_INSERT, rand_value()));
      else if (k < 60) pending_reqs.push_back(make_req(REQ_DEL_MIN, $urandom));
      else if (k < 95) pending_reqs.push_back(make_req(REQ_DEL_MAX, $urandom));
      else pending_reqs.push_back(make_req(REQ_NOP, $urandom));
    end

    wait (pending_reqs.size() < 60);
    calm_phase = 1;
    wait (pending_reqs.size() == 0 && !in_tvalid);
    wait (expected_results.size() == 0);
    repeat (2200) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
